>>> rtl/core/tkeb_pkg.sv
package tkeb_pkg;

    // Defaults for the top-level parameters.
    localparam int TOP_K_DEF       = 5;
    localparam int ENERGY_BITS_DEF = 16;
    localparam int ETA_CELLS_DEF   = 32;

    // Fixed field widths of the cell and result streams.
    localparam int CELL_E_W  = 16;
    localparam int ETA_W     = 5;
    localparam int FRAC_BITS = 8;
    localparam int BARY_W    = 13;

    // Stream widths, padded to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // Divider step counter width.
    localparam int DIV_CNT_W = $clog2(BARY_W + 1);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ACC   = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } seq_state_t;

    // Control from the sequencer to the top-K list.
    typedef struct packed {
        logic insert;
        logic clear;
    } list_ctrl_t;

endpackage

>>> rtl/core/tkeb_list.sv
module tkeb_list
    import tkeb_pkg::*;
#(
    parameter int TOP_K = TOP_K_DEF,
    parameter int E_W   = CELL_E_W,
    parameter int IDX_W = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  list_ctrl_t       ctrl,
    input  logic [E_W-1:0]   ins_energy,
    input  logic [ETA_W-1:0] ins_eta,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [E_W-1:0]   rd_energy,
    output logic [ETA_W-1:0] rd_eta
);

    logic [E_W-1:0]   energy_reg [TOP_K];
    logic [ETA_W-1:0] eta_reg    [TOP_K];
    logic [E_W-1:0]   energy_next[TOP_K];
    logic [ETA_W-1:0] eta_next   [TOP_K];
    logic [TOP_K-1:0] gt;

    // The list is descending, so the greater-than flags form a run that
    // ends at the bottom; the new cell lands where the run starts.
    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            gt[i]          = ins_energy > energy_reg[i];
            energy_next[i] = energy_reg[i];
            eta_next[i]    = eta_reg[i];
            if (gt[i]) begin
                if (i == 0) begin
                    energy_next[i] = ins_energy;
                    eta_next[i]    = ins_eta;
                end else if (!gt[i-1]) begin
                    energy_next[i] = ins_energy;
                    eta_next[i]    = ins_eta;
                end else begin
                    energy_next[i] = energy_reg[i-1];
                    eta_next[i]    = eta_reg[i-1];
                end
            end
        end
    end

    // Entry storage: cleared on reset and at the end of each event.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < TOP_K; i++) begin
                energy_reg[i] <= '0;
                eta_reg[i]    <= '0;
            end
        end else if (ctrl.insert) begin
            for (int i = 0; i < TOP_K; i++) begin
                energy_reg[i] <= energy_next[i];
                eta_reg[i]    <= eta_next[i];
            end
        end
    end

    // Read port used by the accumulation sweep.
    assign rd_energy = energy_reg[rd_idx];
    assign rd_eta    = eta_reg[rd_idx];

endmodule

>>> rtl/core/tkeb_div.sv
module tkeb_div
    import tkeb_pkg::*;
#(
    parameter int SUM_W = 19
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [SUM_W+BARY_W-1:0]       dividend,
    input  logic [SUM_W-1:0]              divisor,
    output logic                          done,
    output logic [BARY_W-1:0]             quotient
);

    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [BARY_W-1:0]    dvd_reg, dvd_next;
    logic [BARY_W-1:0]    quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SUM_W:0]       trial;
    logic [SUM_W:0]       diff;
    logic                 fits;

    // One restoring step per cycle. The caller guarantees the quotient fits
    // in BARY_W bits, so the partial remainder starts as the dividend's
    // upper bits and only BARY_W steps are needed.
    always_comb begin
        trial     = {rem_reg, dvd_reg[BARY_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = trial >= {1'b0, divisor};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[SUM_W+BARY_W-1:BARY_W];
            dvd_next  = dividend[BARY_W-1:0];
            quot_next = '0;
            cnt_next  = DIV_CNT_W'(BARY_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            dvd_next  = {dvd_reg[BARY_W-2:0], 1'b0};
            quot_next = {quot_reg[BARY_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/core/topk_energy_barycenter.sv
// Cells that do not close an event do not stall the input; the next cell is accepted on the next cycle.
// A cell marked last starts a sweep that ends with the result registered:
// one multiply-accumulate per list entry, then one divider step per
// quotient bit. s_tready stays low during that sweep and while a result waits for space.
// Reset (aresetn low, synchronous) clears the list, the sequencer and the output valid.
module topk_energy_barycenter
    import tkeb_pkg::*;
#(
    parameter int TOP_K       = TOP_K_DEF,
    parameter int ENERGY_BITS = ENERGY_BITS_DEF,
    parameter int ETA_CELLS   = ETA_CELLS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // cell_energy[15:0], eta_index[20:16], zero pad
    input  logic                s_tlast,   // last_cell
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // barycenter[12:0], zero pad
    output logic                m_tuser    // ok
);

    localparam int E_W   = (ENERGY_BITS < CELL_E_W) ? ENERGY_BITS : CELL_E_W;
    localparam int CNT_W = $clog2(TOP_K + 1);
    localparam int SUM_W = E_W + CNT_W;
    localparam int NUM_W = SUM_W + ETA_W;
    localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [ETA_W-1:0] ETA_MAX =
        (ETA_CELLS > (2 ** ETA_W)) ? {ETA_W{1'b1}} : ETA_W'(ETA_CELLS - 1);

    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic               m_valid_reg, m_valid_next;
    logic [BARY_W-1:0]  bary_reg, bary_next;
    logic               ok_reg, ok_next;

    logic               accept;
    logic [E_W-1:0]     cell_e;
    logic [ETA_W-1:0]   cell_eta_raw;
    logic [ETA_W-1:0]   cell_eta;
    list_ctrl_t         list_ctrl;
    logic [E_W-1:0]     rd_energy;
    logic [ETA_W-1:0]   rd_eta;
    logic [E_W+ETA_W-1:0] product;
    logic               div_start;
    logic               div_done;
    logic [BARY_W-1:0]  quotient;
    logic               out_free;

    // Input decode: energy masked to the configured width, eta clamped to the grid.
    assign accept       = s_tvalid && s_tready;
    assign cell_e       = s_tdata[E_W-1:0];
    assign cell_eta_raw = s_tdata[CELL_E_W+ETA_W-1:CELL_E_W];
    assign cell_eta     = (cell_eta_raw > ETA_MAX) ? ETA_MAX : cell_eta_raw;

    assign list_ctrl.insert = accept;
    assign list_ctrl.clear  = (state_reg == ST_ACC) && (idx_reg == IDX_W'(TOP_K - 1));

    tkeb_list #(
        .TOP_K (TOP_K),
        .E_W   (E_W),
        .IDX_W (IDX_W)
    ) u_list (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (list_ctrl),
        .ins_energy (cell_e),
        .ins_eta    (cell_eta),
        .rd_idx     (idx_reg),
        .rd_energy  (rd_energy),
        .rd_eta     (rd_eta)
    );

    // The quotient is bounded by the largest eta times 256, so it always fits.
    tkeb_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({num_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign product   = rd_energy * rd_eta;
    assign div_start = (state_reg == ST_START);
    assign out_free  = !m_valid_reg || m_tready;

    // Sequencer: accumulate one list entry per cycle, divide, then hand off.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        num_next     = num_reg;
        m_valid_next = m_valid_reg && !m_tready;
        bary_next    = bary_reg;
        ok_next      = ok_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tlast) begin
                    state_next = ST_ACC;
                    idx_next   = '0;
                    sum_next   = '0;
                    num_next   = '0;
                end
            end
            ST_ACC: begin
                sum_next = sum_reg + SUM_W'(rd_energy);
                num_next = num_reg + NUM_W'(product);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(TOP_K - 1)) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    ok_next      = (sum_reg != '0);
                    bary_next    = (sum_reg != '0) ? quotient : '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Accumulators and result payload.
    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        bary_reg <= bary_next;
        ok_reg   <= ok_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(bary_reg);
    assign m_tuser  = ok_reg;

endmodule

>>> rtl/core/tkeb_checker.sv
module tkeb_checker
    import tkeb_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // A pending result is held until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An event with no energy reports a zero barycenter.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("nonzero barycenter with ok low");

    // The barycenter never exceeds the last eta cell.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[BARY_W-1:0] <= BARY_W'(7936))
        else $error("barycenter out of range");

    // Closing an event stalls the cell stream for the computation.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("cell accepted during barycenter computation");

    // After reset no result is offered.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind topk_energy_barycenter tkeb_checker u_tkeb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkeb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 15;
    localparam int RANDOM_CELLS   = 850;
    localparam int TAIL_CYCLES    = 40;
    localparam int BARY_SAT       = (1 << BARY_W) - 1;

    typedef struct packed {
        logic [CELL_E_W-1:0] energy;
        logic [ETA_W-1:0]    eta;
        logic                last;
    } cell_t;

    typedef struct packed {
        logic [BARY_W-1:0] bary;
        logic              ok;
    } bary_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // cell_energy[15:0], eta_index[20:16], zero pad
    logic                s_tlast  = 1'b0; // last_cell
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // barycenter[12:0], zero pad
    logic                m_tuser;         // ok

    // Cells waiting to be sent and barycenters waiting to come out.
    cell_t cell_q[$];
    bary_t pending_bary_q[$];

    // Our own copy of the top-K list.
    logic [CELL_E_W-1:0] kept_e   [TOP_K_DEF] = '{default: '0};
    logic [ETA_W-1:0]    kept_eta [TOP_K_DEF] = '{default: '0};

    int  cells_total     = 0;
    int  cells_accepted  = 0;
    int  results_checked = 0;
    int  errors          = 0;
    int  idle_cycles     = 0;
    bit  cell_taken      = 1'b0;
    bit  result_taken    = 1'b0;

    topk_energy_barycenter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Offer one cell to the list and, on the last cell of an event, predict the barycenter.
    task automatic rank_cell(input cell_t c);
        int                  slot;
        int                  j;
        logic [ETA_W-1:0]    eta;
        logic [63:0]         e_sum;
        logic [63:0]         e_eta_sum;
        logic [63:0]         quot;
        bary_t               res;
        eta = (int'(c.eta) > ETA_CELLS_DEF - 1) ? ETA_W'(ETA_CELLS_DEF - 1) : c.eta;
        // A strictly larger energy goes in ahead of the first smaller one.
        if (c.energy > kept_e[TOP_K_DEF-1]) begin
            slot = 0;
            while (!(c.energy > kept_e[slot]))
                slot++;
            for (j = TOP_K_DEF - 1; j > slot; j--) begin
                kept_e[j]   = kept_e[j-1];
                kept_eta[j] = kept_eta[j-1];
            end
            kept_e[slot]   = c.energy;
            kept_eta[slot] = eta;
        end
        if (c.last) begin
            e_sum     = '0;
            e_eta_sum = '0;
            for (j = 0; j < TOP_K_DEF; j++) begin
                e_sum     += 64'(kept_e[j]);
                e_eta_sum += 64'(kept_e[j]) * 64'(kept_eta[j]);
            end
            if (e_sum == 0) begin
                res.bary = '0;
                res.ok   = 1'b0;
            end else begin
                quot = (e_eta_sum << FRAC_BITS) / e_sum;
                if (quot > BARY_SAT)
                    quot = BARY_SAT;
                res.bary = quot[BARY_W-1:0];
                res.ok   = 1'b1;
            end
            pending_bary_q.push_back(res);
            for (j = 0; j < TOP_K_DEF; j++) begin
                kept_e[j]   = '0;
                kept_eta[j] = '0;
            end
        end
    endtask

    task automatic queue_cell(input int energy, input int eta, input bit last);
        cell_t c;
        c.energy = CELL_E_W'(energy);
        c.eta    = ETA_W'(eta);
        c.last   = last;
        cell_q.push_back(c);
        cells_total++;
    endtask

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 18));
    endfunction

    // Sender: holds a request until it is taken, then waits a drawn number of cycles.
    int send_wait = 0;
    bit send_calm = 1'b0;

    always @(negedge aclk) begin
        cell_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || cell_taken) begin
            if (cell_taken) begin
                if ($urandom_range(0, 63) == 0)
                    send_calm = ~send_calm;
                send_wait = draw_wait(send_calm);
            end
            if (send_wait > 0 || cell_q.size() == 0) begin
                if (send_wait > 0)
                    send_wait--;
                s_tvalid <= 1'b0;
            end else begin
                c = cell_q.pop_front();
                s_tdata  <= S_DATA_W'({c.eta, c.energy});
                s_tlast  <= c.last;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: stalls a drawn number of cycles per result, once for a long stretch.
    int recv_hold = 0;
    bit recv_calm = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (result_taken) begin
                if ($urandom_range(0, 31) == 0)
                    recv_calm = ~recv_calm;
                if (results_checked == HOLD_AT_RESULT)
                    recv_hold = LONG_HOLD;
                else
                    recv_hold = draw_wait(recv_calm);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on every accepted cell and checks every accepted result.
    always @(posedge aclk) begin
        bary_t want;
        cell_t got;
        cell_taken   = aresetn && s_tvalid && s_tready;
        result_taken = aresetn && m_tvalid && m_tready;
        if (cell_taken) begin
            got.energy = s_tdata[CELL_E_W-1:0];
            got.eta    = s_tdata[CELL_E_W +: ETA_W];
            got.last   = s_tlast;
            rank_cell(got);
            cells_accepted++;
        end
        if (result_taken) begin
            results_checked++;
            if (pending_bary_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got barycenter %0d ok %0b",
                         $time, m_tdata[BARY_W-1:0], m_tuser);
                errors++;
            end else begin
                want = pending_bary_q.pop_front();
                if (m_tdata[BARY_W-1:0] !== want.bary) begin
                    $display("%0t: barycenter mismatch, expected %0d, got %0d",
                             $time, want.bary, m_tdata[BARY_W-1:0]);
                    errors++;
                end
                if (m_tuser !== want.ok) begin
                    $display("%0t: ok flag mismatch, expected %0b, got %0b",
                             $time, want.ok, m_tuser);
                    errors++;
                end
            end
        end
        // Watchdog on stretches with no handshake at all.
        if (cell_taken || result_taken || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("topk_energy_barycenter test failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;
        int len;
        int style;
        int e;
        int k;
        // Empty event: zero sum gives no valid barycenter.
        queue_cell(0, 31, 1'b1);
        // Full-scale energy at the top eta index.
        queue_cell(16'hFFFF, 31, 1'b1);
        // Equal energies keep the earlier cells; zero energy never enters.
        for (k = 1; k <= 6; k++)
            queue_cell(100, k, 1'b0);
        queue_cell(0, 9, 1'b0);
        queue_cell(200, 0, 1'b0);
        queue_cell(100, 7, 1'b1);
        // Alternating bit patterns in both fields.
        queue_cell(16'h5555, 5'b01010, 1'b0);
        queue_cell(16'hAAAA, 5'b10101, 1'b1);
        // Smallest nonzero energy at eta zero.
        queue_cell(1, 0, 1'b1);
        // Ascending energies push out the earlier, smaller ones.
        for (k = 1; k <= 7; k++)
            queue_cell(k, k, k == 7);

        // Random events: mostly short, some longer than the list, varied energy ranges.
        n = 0;
        while (n < RANDOM_CELLS) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                 : $urandom_range(1, 12);
            style = $urandom_range(0, 3);
            for (k = 0; k < len; k++) begin
                case (style)
                    0: e = $urandom_range(0, 16'hFFFF);
                    1: e = $urandom_range(0, 7);
                    2: e = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16'hFFFF);
                    default: e = $urandom_range(16'hF000, 16'hFFFF);
                endcase
                queue_cell(e, $urandom_range(0, 31), k == len - 1);
                n++;
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cells_accepted < cells_total)
            @(posedge aclk);
        while (pending_bary_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("topk_energy_barycenter test passed");
        else
            $display("topk_energy_barycenter test failed");
        $finish;
    end

endmodule
